// ----- rtl/core/zbd_pkg.sv -----
package zbd_pkg;

    // Store geometry and dash length
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;
    localparam int DASH_LENGTH = 10;
    localparam int STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int CNT_W       = $clog2(DASH_LENGTH + 1);

    // Field widths
    localparam int OP_W      = 3;
    localparam int COORD_W   = 16;
    localparam int DEPTH_W   = 32;
    localparam int COLOR_W   = 24;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
    localparam logic [OP_W-1:0] OP_BORDER = 3'd2;
    localparam logic [OP_W-1:0] OP_DASH   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET   = 10'd512;

    // Cleared pixel contents
    localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 32'h8000_0000;
    localparam logic [COLOR_W-1:0] WHITE       = 24'hFF_FFFF;

    typedef logic [ADDR_W-1:0] addr_t;

    // One pixel of the store
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
    } pixel_t;

    // An accepted item as held during its read-modify-write cycle
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
        logic               new_edge;
        logic               in_area;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic [DEPTH_W-1:0] read_depth;
        logic               inside_res;
        logic               wrote;
    } result_t;

    // Swap the red and blue bytes of a 0xBBGGRR color.
    function automatic logic [COLOR_W-1:0] swap_red_blue(input logic [COLOR_W-1:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

// ----- rtl/core/zbd_store.sv -----
module zbd_store (
    input  logic                  clk,
    input  logic                  rd_en,
    input  zbd_pkg::addr_t        rd_addr,
    output zbd_pkg::pixel_t       rd_data,
    input  logic                  wr_en,
    input  zbd_pkg::addr_t        wr_addr,
    input  zbd_pkg::pixel_t       wr_data
);
    import zbd_pkg::*;

    pixel_t mem [STORE_SIZE];

    // Synchronous write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/zbd_fragment.sv -----
module zbd_fragment (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              exec_en,
    input  zbd_pkg::item_t    item,
    input  zbd_pkg::pixel_t   stored,
    output logic              wr_en,
    output zbd_pkg::pixel_t   wr_word,
    output zbd_pkg::result_t  result
);
    import zbd_pkg::*;

    logic             dash_active_reg;
    logic             dash_active_next;
    logic             dash_drawing_reg;
    logic             dash_drawing_next;
    logic [CNT_W-1:0] dash_count_reg;
    logic [CNT_W-1:0] dash_count_next;
    logic [CNT_W-1:0] count_inc;
    logic             nearer;
    logic             not_behind;
    logic             hidden;

    // Depth comparisons against the stored pixel.
    assign nearer     = $signed(item.depth) > $signed(stored.depth);
    assign not_behind = $signed(item.depth) >= $signed(stored.depth);
    assign hidden     = $signed(stored.depth) > $signed(item.depth);

    // Depth test, dash machine and read formatting.
    always_comb
    begin
        wr_en             = 1'b0;
        wr_word           = stored;
        result            = '0;
        dash_active_next  = dash_active_reg;
        dash_drawing_next = dash_drawing_reg;
        dash_count_next   = dash_count_reg;
        count_inc         = '0;
        case (item.op)
            OP_FILL:
            begin
                result.inside_res = item.in_area;
                if (item.in_area && nearer)
                begin
                    wr_en         = 1'b1;
                    wr_word.depth = item.depth;
                    wr_word.color = item.color;
                    result.wrote  = 1'b1;
                end
            end
            OP_BORDER:
            begin
                result.inside_res = item.in_area;
                if (item.in_area && not_behind)
                begin
                    wr_en         = 1'b1;
                    wr_word.depth = item.depth;
                    wr_word.color = item.color;
                    result.wrote  = 1'b1;
                end
            end
            OP_DASH:
            begin
                result.inside_res = item.in_area;
                if (item.new_edge)
                begin
                    dash_active_next  = 1'b0;
                    dash_drawing_next = 1'b0;
                end
                if (item.in_area)
                begin
                    if (hidden)
                    begin
                        if (!dash_active_next)
                        begin
                            dash_active_next  = 1'b1;
                            dash_drawing_next = 1'b1;
                            dash_count_next   = '0;
                        end
                    end
                    else
                    begin
                        dash_active_next = 1'b0;
                    end
                    if (dash_active_next)
                    begin
                        if (dash_drawing_next)
                        begin
                            wr_en         = 1'b1;
                            wr_word.color = item.color;
                            result.wrote  = 1'b1;
                        end
                        count_inc = dash_count_next + CNT_W'(1);
                        if (count_inc >= CNT_W'(DASH_LENGTH))
                        begin
                            dash_drawing_next = !dash_drawing_next;
                            dash_count_next   = '0;
                        end
                        else
                        begin
                            dash_count_next = count_inc;
                        end
                    end
                end
            end
            OP_READ:
            begin
                result.inside_res = item.in_area;
                if (item.in_area)
                begin
                    result.read_color = swap_red_blue(stored.color);
                    result.read_depth = stored.depth;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Dash state advances only on the execute cycle of a dash fragment.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_active_reg  <= 1'b0;
            dash_drawing_reg <= 1'b0;
            dash_count_reg   <= '0;
        end
        else if (exec_en)
        begin
            dash_active_reg  <= dash_active_next;
            dash_drawing_reg <= dash_drawing_next;
            dash_count_reg   <= dash_count_next;
        end
    end

    // A store write on the execute cycle is only for a pixel inside the active rectangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && exec_en |-> item.in_area)
        else $error("store write for a pixel outside the active rectangle");

endmodule

// ----- rtl/core/depth_buffer_with_dashed_hidden_edges.sv -----
// Depth buffer with fill, border, dashed hidden-edge, read and clear operations over a
// 512 x 512 store of depth and color held in one single-port-read, single-port-write
// memory. An item is taken when start is high and busy is low. For a fragment or read,
// the accept edge issues the memory read, and the next cycle tests depth, writes back
// and loads the result, so done rises as that cycle ends and a new item can be accepted
// while done is high. The result must be captured in its done cycle; the receiver
// cannot stall. A clear walks the whole memory one pixel per cycle with busy high, then
// done pulses with wrote set. The same sweep runs after reset, without a result, before
// the first item is taken. Configuration writes are always accepted and should be made
// while no item is pending.
module depth_buffer_with_dashed_hidden_edges (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [zbd_pkg::OP_W-1:0]               operation,
    input  logic signed [zbd_pkg::COORD_W-1:0]     pixel_x,
    input  logic signed [zbd_pkg::COORD_W-1:0]     pixel_y,
    input  logic signed [zbd_pkg::DEPTH_W-1:0]     depth_value,
    input  logic [zbd_pkg::COLOR_W-1:0]            fragment_color,
    input  logic                                   new_edge,
    output logic                                   done,
    output logic [zbd_pkg::COLOR_W-1:0]            read_color,
    output logic signed [zbd_pkg::DEPTH_W-1:0]     read_depth,
    output logic                                   inside_res,
    output logic                                   wrote,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [zbd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [zbd_pkg::CFG_W-1:0]              cfg_data
);
    import zbd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    addr_t            clr_cnt_reg;
    addr_t            clr_cnt_next;
    logic             clr_report_reg;
    logic             clr_report_next;
    logic [CFG_W-1:0] active_columns_reg;
    logic [CFG_W-1:0] active_rows_reg;
    item_t            item_reg;
    addr_t            addr_reg;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic             accept;
    logic             in_area;
    addr_t            pix_addr;
    logic             rd_en;
    pixel_t           rd_data;
    logic             mem_we;
    addr_t            mem_waddr;
    pixel_t           mem_wdata;
    logic             frag_we;
    pixel_t           frag_word;
    result_t          frag_result;
    logic             clr_last;
    item_t            item_in;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_columns_reg <= CFG_RESET;
            active_rows_reg    <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: active_columns_reg <= cfg_data;
                CFG_ROWS:    active_rows_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Rectangle test and pixel address from the input ports.
    assign in_area = !pixel_x[COORD_W-1] && !pixel_y[COORD_W-1]
                  && ($unsigned(pixel_x) < COORD_W'(active_columns_reg))
                  && ($unsigned(pixel_x) < COORD_W'(MAX_COLUMNS))
                  && ($unsigned(pixel_y) < COORD_W'(active_rows_reg))
                  && ($unsigned(pixel_y) < COORD_W'(MAX_ROWS));
    assign pix_addr = ADDR_W'($unsigned(pixel_y)) * ADDR_W'(MAX_COLUMNS)
                    + ADDR_W'($unsigned(pixel_x));

    assign item_in.op       = operation;
    assign item_in.depth    = depth_value;
    assign item_in.color    = fragment_color;
    assign item_in.new_edge = new_edge;
    assign item_in.in_area  = in_area;

    assign rd_en = accept && (operation != OP_CLEAR);

    // Hold the accepted item for its execute cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
            addr_reg <= pix_addr;
        end
    end

    assign clr_last = (clr_cnt_reg == addr_t'(STORE_SIZE - 1));

    // Sequencer: clear sweep, idle, execute.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + addr_t'(1);
                if (clr_last)
                begin
                    state_next      = ST_IDLE;
                    clr_report_next = 1'b0;
                    done_next       = clr_report_reg;
                    result_next     = '0;
                    result_next.wrote = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_CLEAR)
                    begin
                        state_next      = ST_CLEAR;
                        clr_cnt_next    = '0;
                        clr_report_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = frag_result;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done       = done_reg;
    assign read_color = result_reg.read_color;
    assign read_depth = result_reg.read_depth;
    assign inside_res = result_reg.inside_res;
    assign wrote      = result_reg.wrote;

    // Depth test and dash machine on the read data.
    zbd_fragment u_fragment (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec_en (state_reg == ST_EXEC),
        .item    (item_reg),
        .stored  (rd_data),
        .wr_en   (frag_we),
        .wr_word (frag_word),
        .result  (frag_result)
    );

    // Write port is shared by the clear sweep and the execute cycle.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we          = 1'b1;
            mem_waddr       = clr_cnt_reg;
            mem_wdata.depth = DEPTH_FLOOR;
            mem_wdata.color = WHITE;
        end
        else
        begin
            mem_we    = frag_we && (state_reg == ST_EXEC);
            mem_waddr = addr_reg;
            mem_wdata = frag_word;
        end
    end

    zbd_store u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (pix_addr),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    // The store is never written while the block waits for work.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mem_we)
        else $error("store written while idle");

    // Every accepted fragment or read yields its result with done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation != OP_CLEAR |=> ##1 done)
        else $error("missing result after fragment or read");

    // Every result follows a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without preceding work");

    // A result flagged inside never comes from a clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && inside_res |-> $past(state_reg == ST_EXEC))
        else $error("inside flag on a clear result");

endmodule

// ----- dv/depth_buffer_with_dashed_hidden_edges_tb.sv -----
`timescale 1ns / 100ps

module depth_buffer_with_dashed_hidden_edges_tb;

    import zbd_pkg::*;

    // Operation codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [DEPTH_W-1:0] Z_NEAREST  = 32'sh7FFF_FFFF;
    localparam logic signed [DEPTH_W-1:0] Z_FARTHEST = 32'sh8000_0000;

    localparam int GAP_MAX            = 7;
    localparam int PHASES             = 8;
    localparam int ITEMS_PER_PHASE    = 140;
    localparam int SPARSE_PHASE_ITEMS = 40;
    localparam int CLEAR_PHASE        = 5;
    localparam int HOT_SPAN           = 12;
    localparam int SETTLE_CYCLES      = 8;
    // A clear holds busy for one pass over the store, so allow several such passes.
    localparam int STALL_LIMIT        = 4 * STORE_SIZE;

    // One input transaction as the sender sees it.
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0]        color;
        logic                      starts_edge;
    } fragment_t;

    // Shadow copy of the depth and color store, the dash machine and the registers.
    class zbuffer_shadow;
        logic [DEPTH_W-1:0] depth_mem [int];
        logic [COLOR_W-1:0] color_mem [int];
        int unsigned        run_length;
        bit                 run_active;
        bit                 run_drawing;
        logic [CFG_W-1:0]   columns_reg;
        logic [CFG_W-1:0]   rows_reg;
        result_t            pixel_replies [$];
        int                 errors;
        int                 checked;
        int                 pixel_writes;
        int                 dash_draws;
        int                 clears;

        function new();
            columns_reg = CFG_RESET;
            rows_reg    = CFG_RESET;
        endfunction

        function int span_cols();
            return (columns_reg < MAX_COLUMNS) ? int'(columns_reg) : MAX_COLUMNS;
        endfunction

        function int span_rows();
            return (rows_reg < MAX_ROWS) ? int'(rows_reg) : MAX_ROWS;
        endfunction

        function int pending();
            return pixel_replies.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_COLUMNS)
                columns_reg = value;
            else if (index == CFG_ROWS)
                rows_reg = value;
        endfunction

        // A pixel never written since the last clear holds the cleared contents.
        function logic signed [DEPTH_W-1:0] depth_at(int idx);
            return depth_mem.exists(idx) ? depth_mem[idx] : DEPTH_FLOOR;
        endfunction

        function logic [COLOR_W-1:0] color_at(int idx);
            return color_mem.exists(idx) ? color_mem[idx] : WHITE;
        endfunction

        // Apply one accepted transaction and queue the reply it must produce.
        // Returns 1 when the transaction hit the active rectangle or was a clear.
        function bit accept_fragment(fragment_t f);
            result_t                   r;
            bit                        in_rect;
            int                        idx;
            logic signed [DEPTH_W-1:0] stored;
            logic [COLOR_W-1:0]        c;

            r       = '0;
            in_rect = (f.x >= 0) && (f.y >= 0) &&
                      (int'(f.x) < span_cols()) && (int'(f.y) < span_rows());
            idx     = in_rect ? int'(f.y) * MAX_COLUMNS + int'(f.x) : 0;
            stored  = in_rect ? depth_at(idx) : DEPTH_FLOOR;

            case (f.op)
                OP_CLEAR:
                begin
                    // The whole store is cleared; dash state survives.
                    depth_mem.delete();
                    color_mem.delete();
                    in_rect = 1'b0;
                    r.wrote = 1'b1;
                    clears++;
                end
                OP_FILL:
                begin
                    if (in_rect && f.z > stored)
                    begin
                        depth_mem[idx] = f.z;
                        color_mem[idx] = f.color;
                        r.wrote        = 1'b1;
                    end
                end
                OP_BORDER:
                begin
                    // z + 1 > stored without wrapping is the same as z >= stored.
                    if (in_rect && f.z >= stored)
                    begin
                        depth_mem[idx] = f.z;
                        color_mem[idx] = f.color;
                        r.wrote        = 1'b1;
                    end
                end
                OP_DASH:
                begin
                    if (f.starts_edge)
                    begin
                        run_active  = 1'b0;
                        run_drawing = 1'b0;
                    end
                    if (in_rect)
                    begin
                        // A hidden point with no run active starts a new run with a drawn dash.
                        if (stored > f.z)
                        begin
                            if (!run_active)
                            begin
                                run_active  = 1'b1;
                                run_drawing = 1'b1;
                                run_length  = 0;
                            end
                        end
                        else
                            run_active = 1'b0;
                        if (run_active)
                        begin
                            if (run_drawing)
                            begin
                                color_mem[idx] = f.color;
                                r.wrote        = 1'b1;
                                dash_draws++;
                            end
                            run_length++;
                            if (run_length >= DASH_LENGTH)
                            begin
                                run_drawing = !run_drawing;
                                run_length  = 0;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (in_rect)
                    begin
                        c            = color_at(idx);
                        r.read_color = {c[7:0], c[15:8], c[23:16]};
                        r.read_depth = depth_at(idx);
                    end
                end
                default:
                    in_rect = 1'b0;
            endcase

            r.inside_res = in_rect;
            if (r.wrote && f.op != OP_CLEAR)
                pixel_writes++;
            pixel_replies = {pixel_replies, r};
            return in_rect || f.op == OP_CLEAR;
        endfunction

        // Each mismatch is printed on one line and counted.
        task report_mismatch(string what, logic [DEPTH_W-1:0] got, logic [DEPTH_W-1:0] want);
            errors++;
            $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        endtask

        // Compare one reply transaction with the oldest one still awaited.
        task check_reply(result_t got);
            result_t want;

            checked++;
            if (pixel_replies.size() == 0)
            begin
                report_mismatch("reply with none awaited", got.read_depth, '0);
                return;
            end
            want = pixel_replies.pop_front();
            if (got.read_color !== want.read_color)
                report_mismatch("read_color", DEPTH_W'(got.read_color),
                                DEPTH_W'(want.read_color));
            if (got.read_depth !== want.read_depth)
                report_mismatch("read_depth", got.read_depth, want.read_depth);
            if (got.inside_res !== want.inside_res)
                report_mismatch("inside_res", DEPTH_W'(got.inside_res),
                                DEPTH_W'(want.inside_res));
            if (got.wrote !== want.wrote)
                report_mismatch("wrote", DEPTH_W'(got.wrote), DEPTH_W'(want.wrote));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic signed [DEPTH_W-1:0] depth_value;
    logic [COLOR_W-1:0]        fragment_color;
    logic                      new_edge;
    logic                      done;
    logic [COLOR_W-1:0]        read_color;
    logic signed [DEPTH_W-1:0] read_depth;
    logic                      inside_res;
    logic                      wrote;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    zbuffer_shadow shadow = new();

    bit gap_free;
    int touched_items;
    int sent_items;
    int settings;
    int stall_cycles;

    depth_buffer_with_dashed_hidden_edges dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .depth_value    (depth_value),
        .fragment_color (fragment_color),
        .new_edge       (new_edge),
        .done           (done),
        .read_color     (read_color),
        .read_depth     (read_depth),
        .inside_res     (inside_res),
        .wrote          (wrote),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every reply transaction is taken in its done cycle.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            shadow.check_reply({read_color, read_depth, inside_res, wrote});
    end

    // Stop a hung run: count cycles in which no transaction moves on either side.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic fragment_t make_fragment(
        input logic [OP_W-1:0]           op,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [DEPTH_W-1:0] z,
        input logic [COLOR_W-1:0]        color,
        input logic                      starts_edge
    );
        fragment_t f;

        f.op          = op;
        f.x           = x;
        f.y           = y;
        f.z           = z;
        f.color       = color;
        f.starts_edge = starts_edge;
        return f;
    endfunction

    // Coordinates cluster in a small corner so that pixels are hit again and again,
    // with some on the rectangle's edge, some negative and some anywhere in range.
    function automatic logic signed [COORD_W-1:0] near_coord(input int span);
        int hot;
        int pick;

        hot  = (span < HOT_SPAN) ? span + 1 : HOT_SPAN;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return COORD_W'(-int'($urandom_range(1, 4)));
        if (pick == 1)
            return COORD_W'(span - 1 + int'($urandom_range(0, 2)));
        if (pick == 2)
            return COORD_W'(int'($urandom_range(0, span)));
        return COORD_W'(int'($urandom_range(0, hot - 1)));
    endfunction

    // Depths mostly near zero so that tests go both ways, plus the extremes.
    function automatic logic signed [DEPTH_W-1:0] random_depth();
        int pick;

        pick = $urandom_range(0, 19);
        case (pick)
            0:       return Z_NEAREST;
            1:       return Z_FARTHEST;
            2:       return DEPTH_W'($urandom);
            default: return DEPTH_W'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic fragment_t random_fragment();
        fragment_t f;
        int        pick;

        pick          = $urandom_range(0, 99);
        f.x           = near_coord(shadow.span_cols());
        f.y           = near_coord(shadow.span_rows());
        f.z           = random_depth();
        f.color       = COLOR_W'($urandom);
        f.starts_edge = ($urandom_range(0, 7) == 0);
        if (pick < 30)
            f.op = OP_FILL;
        else if (pick < 50)
            f.op = OP_BORDER;
        else if (pick < 68)
            f.op = OP_DASH;
        else if (pick < 90)
            f.op = OP_READ;
        else if (pick < 93)
            f.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        else
        begin
            // Noise: every field over its full width; never a clear.
            f.op          = OP_W'($urandom_range(OP_FILL, OP_SPARE_LAST));
            f.x           = COORD_W'($urandom);
            f.y           = COORD_W'($urandom);
            f.z           = DEPTH_W'($urandom);
            f.starts_edge = 1'($urandom_range(0, 1));
        end
        return f;
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_item(input fragment_t f);
        int gap;

        gap = gap_free ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        operation      <= f.op;
        pixel_x        <= f.x;
        pixel_y        <= f.y;
        depth_value    <= f.z;
        fragment_color <= f.color;
        new_edge       <= f.starts_edge;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (shadow.accept_fragment(f))
            touched_items++;
        sent_items++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        shadow.set_register(index, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the sender until every awaited reply is in, then let the block settle.
    task automatic wait_for_replies();
        start <= 1'b0;
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // An object in front along a row, then an edge passing behind it, so that the
    // dash machine runs through drawn and skipped runs; a few points poke through.
    task automatic draw_hidden_edge();
        int                        run_len;
        int                        i;
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [DEPTH_W-1:0] front;
        logic signed [DEPTH_W-1:0] z;
        logic [COLOR_W-1:0]        ink;

        run_len = $urandom_range(4, 28);
        x0      = near_coord(shadow.span_cols());
        y0      = near_coord(shadow.span_rows());
        front   = DEPTH_W'(int'($urandom_range(0, 64)) - 32);
        ink     = COLOR_W'($urandom);
        for (i = 0; i < run_len; i++)
        begin
            z = DEPTH_W'(int'(front) + int'($urandom_range(0, 3)));
            send_item(make_fragment(OP_FILL, COORD_W'(x0 + i), y0, z, COLOR_W'($urandom), 1'b0));
        end
        for (i = 0; i < run_len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                z = DEPTH_W'(int'(front) + 8);
            else
                z = DEPTH_W'(int'(front) - 1 - int'($urandom_range(0, 6)));
            send_item(make_fragment(OP_DASH, COORD_W'(x0 + i), y0, z, ink,
                                    i == 0 && $urandom_range(0, 3) != 0));
        end
        for (i = 0; i < run_len; i += 3)
            send_item(make_fragment(OP_READ, COORD_W'(x0 + i), y0, '0, '0, 1'b0));
    endtask

    initial
    begin
        logic [CFG_W-1:0] col_plan [PHASES];
        logic [CFG_W-1:0] row_plan [PHASES];
        int               phase;
        int               budget;
        int               o;

        // Every input known from time zero, with reset held low at first.
        rst_n          = 1'b0;
        start          = 1'b0;
        operation      = OP_READ;
        pixel_x        = '0;
        pixel_y        = '0;
        depth_value    = '0;
        fragment_color = '0;
        new_edge       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_COLUMNS;
        cfg_data       = CFG_RESET;
        gap_free       = 1'b0;
        settings       = 1;
        col_plan = '{10'd0, 10'd1, 10'd1023, 10'd9, 10'd12, 10'd511, 10'd20, 10'd512};
        row_plan = '{10'd512, 10'd1, 10'd1023, 10'd0, 10'd6, 10'd3, 10'd20, 10'd512};
        col_plan[6] = CFG_W'($urandom_range(1, 40));
        row_plan[6] = CFG_W'($urandom_range(1, 40));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed transactions on the reset rectangle of 512 x 512.
        // A cleared pixel reads back white at the most negative depth.
        send_item(make_fragment(OP_READ, 0, 0, '0, '0, 1'b0));
        // At the floor depth a fill loses and a border wins.
        send_item(make_fragment(OP_FILL, 0, 0, Z_FARTHEST, 24'h0000FF, 1'b0));
        send_item(make_fragment(OP_BORDER, 0, 0, Z_FARTHEST, 24'h0000FF, 1'b0));
        send_item(make_fragment(OP_READ, 0, 0, '0, '0, 1'b0));
        // Far corner at the nearest depth: the border's z + 1 must not wrap.
        send_item(make_fragment(OP_FILL, 511, 511, Z_NEAREST, 24'h123456, 1'b0));
        send_item(make_fragment(OP_BORDER, 511, 511, Z_NEAREST, 24'hFFFFFF, 1'b0));
        send_item(make_fragment(OP_FILL, 511, 511, Z_NEAREST, 24'h000000, 1'b0));
        send_item(make_fragment(OP_READ, 511, 511, '0, '0, 1'b0));
        // Negative and out-of-range coordinates touch nothing.
        send_item(make_fragment(OP_FILL, -1, 0, Z_NEAREST, 24'hFFFFFF, 1'b0));
        send_item(make_fragment(OP_FILL, 0, -32768, Z_NEAREST, 24'hFFFFFF, 1'b0));
        send_item(make_fragment(OP_READ, 512, 0, '0, '0, 1'b0));
        send_item(make_fragment(OP_READ, 0, 512, '0, '0, 1'b0));
        send_item(make_fragment(OP_READ, 32767, 32767, '0, '0, 1'b0));
        // A hidden point is drawn, a visible one is not, and an outside one with
        // new_edge only drops the dash flags.
        send_item(make_fragment(OP_FILL, 2, 0, 100, 24'h00FF00, 1'b0));
        send_item(make_fragment(OP_DASH, 2, 0, 50, 24'hFF0000, 1'b1));
        send_item(make_fragment(OP_DASH, 3, 0, 50, 24'hFF0000, 1'b0));
        send_item(make_fragment(OP_DASH, -5, 7, 50, 24'hFF0000, 1'b1));
        send_item(make_fragment(OP_READ, 2, 0, '0, '0, 1'b0));
        // Spare operation codes produce an all-zero reply.
        for (o = int'(OP_SPARE_FIRST); o <= int'(OP_SPARE_LAST); o++)
            send_item(make_fragment(OP_W'(o), 2, 0, Z_NEAREST, 24'hFFFFFF, 1'b1));
        // A clear wipes the whole store.
        send_item(make_fragment(OP_CLEAR, 9, 9, Z_NEAREST, 24'h000000, 1'b1));
        send_item(make_fragment(OP_READ, 511, 511, '0, '0, 1'b0));
        send_item(make_fragment(OP_READ, 2, 0, '0, '0, 1'b0));

        // Random phases, each under its own rectangle, with the block drained between.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_replies();
            write_register(CFG_COLUMNS, col_plan[phase]);
            write_register(CFG_ROWS, row_plan[phase]);
            settings++;
            if (phase == CLEAR_PHASE)
                send_item(make_fragment(OP_CLEAR, '0, '0, '0, '0, 1'b0));
            budget = (shadow.span_cols() == 0 || shadow.span_rows() == 0) ?
                     SPARSE_PHASE_ITEMS : ITEMS_PER_PHASE;
            touched_items = 0;
            sent_items    = 0;
            while (touched_items < budget && sent_items < 3 * budget)
            begin
                if ($urandom_range(0, 63) == 0)
                    gap_free = !gap_free;
                if ($urandom_range(0, 19) == 0)
                    draw_hidden_edge();
                else
                    send_item(random_fragment());
            end
        end

        wait_for_replies();
        $display("Checked %0d replies under %0d rectangle settings: %0d pixel writes,",
                 shadow.checked, settings, shadow.pixel_writes);
        $display("%0d dashed hidden points drawn, %0d full clears, %0d mismatches.",
                 shadow.dash_draws, shadow.clears, shadow.errors);
        if (shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
